// File: design/affine_warp_bilinear_defines.svh
// assertion macros for the warp engine
`ifndef AFFINE_WARP_BILINEAR_DEFINES_SVH
`define AFFINE_WARP_BILINEAR_DEFINES_SVH
`ifndef SYNTH
`define AWB_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define AWB_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define AWB_ASSERT_IMP(lbl, clk, rst_n, a, c, msg)
`define AWB_ASSERT_NXT(lbl, clk, rst_n, a, c, msg)
`endif
`endif

// File: design/awb_pkg.sv
package awb_pkg;
  localparam int MAX_SRC_DIM = 512;
  localparam int SRC_BITS    = $clog2(MAX_SRC_DIM);
  localparam int DIM_W       = 10;
  localparam int BANK_AW     = 2 * (SRC_BITS - 1);
  localparam int NUM_BANKS   = 4;
  localparam int PROD_W      = 42;
  localparam int SUM_W       = 44;
  localparam int INT_W       = SUM_W - 16;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [2:0] REG_COEF_XX  = 3'd0;
  localparam logic [2:0] REG_COEF_XY  = 3'd1;
  localparam logic [2:0] REG_COEF_YX  = 3'd2;
  localparam logic [2:0] REG_COEF_YY  = 3'd3;
  localparam logic [2:0] REG_OFFSET_X = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y = 3'd5;
  localparam logic [2:0] REG_SRC_W    = 3'd6;
  localparam logic [2:0] REG_SRC_H    = 3'd7;

  typedef struct packed {
    logic signed [31:0] coef_xx;
    logic signed [31:0] coef_xy;
    logic signed [31:0] coef_yx;
    logic signed [31:0] coef_yy;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic [DIM_W-1:0]   src_w;
    logic [DIM_W-1:0]   src_h;
  } cfg_t;

  typedef struct packed {
    logic                op;
    logic [SRC_BITS-1:0] cx;
    logic [SRC_BITS-1:0] cy;
    logic [7:0]          pix;
  } item_t;

  // one stage-three word: bank requests plus what the blend needs
  typedef struct packed {
    logic                              valid;
    logic                              op;
    logic                              in_img;
    logic [NUM_BANKS-1:0]              we;
    logic [NUM_BANKS-1:0][BANK_AW-1:0] addr;
    logic [7:0]                        wdata;
    logic [15:0]                       fx;
    logic [15:0]                       fy;
    logic                              px;
    logic                              py;
  } map_out_t;

  typedef struct packed {
    logic        valid;
    logic        op;
    logic        in_img;
    logic [15:0] fx;
    logic [15:0] fy;
    logic        px;
    logic        py;
  } blend_ctl_t;
endpackage

// File: design/awb_ram.sv
module awb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;
endmodule

// File: design/awb_map.sv
module awb_map (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  awb_pkg::item_t      item,
  input  awb_pkg::cfg_t       cfg,
  output awb_pkg::map_out_t   mo
);
  // stage 1: products
  logic                            s1_valid_r;
  awb_pkg::item_t                  s1_item_r;
  logic signed [awb_pkg::PROD_W-1:0] pxx_r, pxy_r, pyx_r, pyy_r;
  // stage 2: sums
  logic                            s2_valid_r;
  awb_pkg::item_t                  s2_item_r;
  logic signed [awb_pkg::SUM_W-1:0]  sx_r, sy_r;
  // stage 3: bound check and bank addresses
  awb_pkg::map_out_t               s3_r, s3_nxt;

  logic signed [9:0] cxs, cys;
  assign cxs = $signed({1'b0, item.cx});
  assign cys = $signed({1'b0, item.cy});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_r.valid <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_vld;
      s2_valid_r <= s1_valid_r;
      s3_r.valid <= s3_nxt.valid;
    end
    if (en) begin
      s1_item_r <= item;
      pxx_r <= cfg.coef_xx * cxs;
      pxy_r <= cfg.coef_xy * cys;
      pyx_r <= cfg.coef_yx * cxs;
      pyy_r <= cfg.coef_yy * cys;
      s2_item_r <= s1_item_r;
      sx_r <= awb_pkg::SUM_W'(pxx_r) + awb_pkg::SUM_W'(pxy_r) + awb_pkg::SUM_W'(cfg.offset_x);
      sy_r <= awb_pkg::SUM_W'(pyx_r) + awb_pkg::SUM_W'(pyy_r) + awb_pkg::SUM_W'(cfg.offset_y);
      s3_r.op     <= s3_nxt.op;
      s3_r.in_img <= s3_nxt.in_img;
      s3_r.we     <= s3_nxt.we;
      s3_r.addr   <= s3_nxt.addr;
      s3_r.wdata  <= s3_nxt.wdata;
      s3_r.fx     <= s3_nxt.fx;
      s3_r.fy     <= s3_nxt.fy;
      s3_r.px     <= s3_nxt.px;
      s3_r.py     <= s3_nxt.py;
    end
  end

  logic signed [awb_pkg::INT_W-1:0] nx, ny, wm1, hm1;
  logic [awb_pkg::DIM_W-1:0]        wc, hc;
  logic [awb_pkg::SRC_BITS-1:0]     nx9, ny9, xb, yb;
  logic                             bx, by;

  always_comb begin
    nx = sx_r[awb_pkg::SUM_W-1:16];
    ny = sy_r[awb_pkg::SUM_W-1:16];
    // size above the store counts as the store size
    wc = (cfg.src_w > awb_pkg::DIM_W'(awb_pkg::MAX_SRC_DIM)) ?
         awb_pkg::DIM_W'(awb_pkg::MAX_SRC_DIM) : cfg.src_w;
    hc = (cfg.src_h > awb_pkg::DIM_W'(awb_pkg::MAX_SRC_DIM)) ?
         awb_pkg::DIM_W'(awb_pkg::MAX_SRC_DIM) : cfg.src_h;
    wm1 = $signed(awb_pkg::INT_W'(wc)) - awb_pkg::INT_W'(1);
    hm1 = $signed(awb_pkg::INT_W'(hc)) - awb_pkg::INT_W'(1);
    nx9 = nx[awb_pkg::SRC_BITS-1:0];
    ny9 = ny[awb_pkg::SRC_BITS-1:0];
    xb  = '0;
    yb  = '0;
    s3_nxt        = '0;
    s3_nxt.valid  = s2_valid_r;
    s3_nxt.op     = s2_item_r.op;
    s3_nxt.in_img = !nx[awb_pkg::INT_W-1] && !ny[awb_pkg::INT_W-1] && (nx < wm1) && (ny < hm1);
    s3_nxt.wdata  = s2_item_r.pix;
    s3_nxt.fx     = sx_r[15:0];
    s3_nxt.fy     = sy_r[15:0];
    s3_nxt.px     = nx9[0];
    s3_nxt.py     = ny9[0];
    for (int b = 0; b < awb_pkg::NUM_BANKS; b++) begin
      bx = b[0];
      by = b[1];
      if (s2_item_r.op == awb_pkg::OP_WRITE) begin
        s3_nxt.we[b] = s2_valid_r && (s2_item_r.cx[0] == bx) && (s2_item_r.cy[0] == by);
        s3_nxt.addr[b] = {s2_item_r.cy[awb_pkg::SRC_BITS-1:1],
                          s2_item_r.cx[awb_pkg::SRC_BITS-1:1]};
      end else begin
        // pick the one of x, x+1 whose parity this bank holds
        xb = nx9 + awb_pkg::SRC_BITS'(bx ^ nx9[0]);
        yb = ny9 + awb_pkg::SRC_BITS'(by ^ ny9[0]);
        s3_nxt.addr[b] = {yb[awb_pkg::SRC_BITS-1:1], xb[awb_pkg::SRC_BITS-1:1]};
      end
    end
  end

  assign mo = s3_r;
endmodule

// File: design/awb_blend.sv
module awb_blend (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  awb_pkg::blend_ctl_t                   ctl,
  input  logic [awb_pkg::NUM_BANKS-1:0][7:0]    rd,
  output logic                                  res_valid,
  output logic [7:0]                            res_pixel,
  output logic                                  res_inside
);
  logic        s5_valid_r, s5_op_r, s5_in_r;
  logic [15:0] s5_fy_r;
  logic [24:0] top_r, bot_r;
  logic        s6_valid_r, s6_in_r;
  logic [7:0]  s6_pix_r;

  logic [7:0]  p00, p01, p10, p11;
  logic [16:0] wx, wy;
  logic [24:0] top_nxt, bot_nxt;
  logic [40:0] q;

  always_comb begin
    p00 = rd[{ctl.py, ctl.px}];
    p01 = rd[{ctl.py, ~ctl.px}];
    p10 = rd[{~ctl.py, ctl.px}];
    p11 = rd[{~ctl.py, ~ctl.px}];
    wx = 17'h10000 - {1'b0, ctl.fx};
    top_nxt = 25'(p00 * wx) + 25'(p01 * {1'b0, ctl.fx});
    bot_nxt = 25'(p10 * wx) + 25'(p11 * {1'b0, ctl.fx});
    wy = 17'h10000 - {1'b0, s5_fy_r};
    q = 41'(top_r * wy) + 41'(bot_r * {1'b0, s5_fy_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= ctl.valid && (ctl.op == awb_pkg::OP_SAMPLE);
      s6_valid_r <= s5_valid_r;
    end
    if (en) begin
      s5_op_r  <= ctl.op;
      s5_in_r  <= ctl.in_img;
      s5_fy_r  <= ctl.fy;
      top_r    <= top_nxt;
      bot_r    <= bot_nxt;
      s6_in_r  <= s5_in_r && (s5_op_r == awb_pkg::OP_SAMPLE);
      s6_pix_r <= s5_in_r ? q[39:32] : 8'd0;
    end
  end

  assign res_valid  = s6_valid_r;
  assign res_pixel  = s6_pix_r;
  assign res_inside = s6_in_r;
endmodule

// File: design/affine_warp_bilinear.sv
// inverse affine warp with bilinear blend. a write word (operation 0) stores one
// grey pixel; a sample word (operation 1) maps its output coordinate through the
// q16.16 matrix and offset and returns the blended value, or 0 with inside_res
// low when the 2x2 neighbourhood leaves the source. the block takes one word per
// clock while the pipe advances; a sample's result word passes the six register
// stages (products, sums, bound check, ram read, row blend, column blend), the
// first of which loads at the accepting edge itself. the source frame lives in
// four ram banks split by row and column parity, so every neighbourhood reads
// one pixel from each bank in the same cycle. writes and reads meet the banks at
// the same stage, so a sample sees every earlier write. the whole pipe advances
// together and holds when a result waits to be taken; write words leave no
// result. pixels never written read back as anything. registers are to be
// written only while the pipe is empty; the block itself does not enforce it.
`include "affine_warp_bilinear_defines.svh"
module affine_warp_bilinear (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [8:0]  in_coord_x,
  input  logic [8:0]  in_coord_y,
  input  logic [7:0]  in_pixel_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel_out,
  output logic        out_inside_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  awb_pkg::cfg_t     cfg_r;
  awb_pkg::item_t    item;
  awb_pkg::map_out_t mo;
  awb_pkg::blend_ctl_t s4_r;
  logic [awb_pkg::NUM_BANKS-1:0][7:0] rd;
  logic adv;

  // the pipe moves whenever the output slot is empty or being emptied
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_xx  <= 32'sd63856;
      cfg_r.coef_xy  <= 32'sd15754;
      cfg_r.coef_yx  <= -32'sd52723;
      cfg_r.coef_yy  <= 32'sd35919;
      cfg_r.offset_x <= 32'sd3376802;
      cfg_r.offset_y <= 32'sd20292633;
      cfg_r.src_w    <= awb_pkg::DIM_W'(awb_pkg::MAX_SRC_DIM);
      cfg_r.src_h    <= awb_pkg::DIM_W'(awb_pkg::MAX_SRC_DIM);
    end else if (cfg_we) begin
      case (cfg_index)
        awb_pkg::REG_COEF_XX:  cfg_r.coef_xx  <= cfg_data;
        awb_pkg::REG_COEF_XY:  cfg_r.coef_xy  <= cfg_data;
        awb_pkg::REG_COEF_YX:  cfg_r.coef_yx  <= cfg_data;
        awb_pkg::REG_COEF_YY:  cfg_r.coef_yy  <= cfg_data;
        awb_pkg::REG_OFFSET_X: cfg_r.offset_x <= cfg_data;
        awb_pkg::REG_OFFSET_Y: cfg_r.offset_y <= cfg_data;
        awb_pkg::REG_SRC_W:    cfg_r.src_w    <= cfg_data[awb_pkg::DIM_W-1:0];
        awb_pkg::REG_SRC_H:    cfg_r.src_h    <= cfg_data[awb_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign item.op  = in_operation;
  assign item.cx  = in_coord_x;
  assign item.cy  = in_coord_y;
  assign item.pix = in_pixel_in;

  // stages 1 to 3: coordinate map, floor/fraction split, bank requests
  awb_map u_map (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .in_vld (in_valid),
    .item   (item),
    .cfg    (cfg_r),
    .mo     (mo)
  );

  // stage 4: banked source frame, one port per bank
  for (genvar b = 0; b < awb_pkg::NUM_BANKS; b++) begin : g_bank
    awb_ram #(
      .WIDTH (8),
      .DEPTH (1 << awb_pkg::BANK_AW)
    ) u_ram (
      .clk   (clk),
      .en    (adv && mo.valid),
      .we    (mo.we[b]),
      .addr  (mo.addr[b]),
      .wdata (mo.wdata),
      .rdata (rd[b])
    );
  end

  // control that travels alongside the ram read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.valid <= 1'b0;
    end else if (adv) begin
      s4_r.valid <= mo.valid;
    end
    if (adv) begin
      s4_r.op     <= mo.op;
      s4_r.in_img <= mo.in_img;
      s4_r.fx     <= mo.fx;
      s4_r.fy     <= mo.fy;
      s4_r.px     <= mo.px;
      s4_r.py     <= mo.py;
    end
  end

  // stages 5 and 6: row blend, column blend into the output register
  awb_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .ctl        (s4_r),
    .rd         (rd),
    .res_valid  (out_valid),
    .res_pixel  (out_pixel_out),
    .res_inside (out_inside_res)
  );

  // an outside sample carries a zero pixel
  `AWB_ASSERT_IMP(a_outside_zero, clk, rst_n, out_valid && !out_inside_res, out_pixel_out == 8'd0, "outside sample with nonzero pixel")
  // a sample word never writes a bank
  `AWB_ASSERT_IMP(a_sample_no_write, clk, rst_n, mo.valid && (mo.op == awb_pkg::OP_SAMPLE), mo.we == '0, "sample word drives a bank write")
  // a write word writes exactly one bank
  `AWB_ASSERT_IMP(a_write_one_bank, clk, rst_n, mo.valid && (mo.op == awb_pkg::OP_WRITE), $onehot(mo.we), "write word hits other than one bank")
endmodule

// File: tb/affine_warp_bilinear_checker.sv
module affine_warp_bilinear_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_operation,
  input  logic [8:0]  in_coord_x,
  input  logic [8:0]  in_coord_y,
  input  logic [7:0]  in_pixel_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_pixel_out,
  input  logic        out_inside_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [7:0] pixel;
    logic       hit;
  } warp_res_t;

  awb_pkg::cfg_t regs;
  logic [7:0]    frame [0:awb_pkg::MAX_SRC_DIM*awb_pkg::MAX_SRC_DIM-1];
  warp_res_t     due_q [$];

  initial fail_count = 0;
  assign pending = due_q.size();

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic warp_res_t warp_sample(logic [8:0] cx, logic [8:0] cy);
    warp_res_t r;
    longint sx, sy, nx, ny, w, h;
    longint unsigned fx, fy, p00, p01, p10, p11, top, bot, q;
    r = '0;
    sx = longint'(regs.coef_xx) * longint'(cx) + longint'(regs.coef_xy) * longint'(cy)
         + longint'(regs.offset_x);
    sy = longint'(regs.coef_yx) * longint'(cx) + longint'(regs.coef_yy) * longint'(cy)
         + longint'(regs.offset_y);
    nx = sx >>> 16;
    ny = sy >>> 16;
    fx = longint'(sx[15:0]);
    fy = longint'(sy[15:0]);
    w = (regs.src_w > awb_pkg::MAX_SRC_DIM) ? awb_pkg::MAX_SRC_DIM : longint'(regs.src_w);
    h = (regs.src_h > awb_pkg::MAX_SRC_DIM) ? awb_pkg::MAX_SRC_DIM : longint'(regs.src_h);
    if (nx < 0 || ny < 0 || nx + 1 >= w || ny + 1 >= h) return r;
    p00 = frame[ny * awb_pkg::MAX_SRC_DIM + nx];
    p01 = frame[ny * awb_pkg::MAX_SRC_DIM + nx + 1];
    p10 = frame[(ny + 1) * awb_pkg::MAX_SRC_DIM + nx];
    p11 = frame[(ny + 1) * awb_pkg::MAX_SRC_DIM + nx + 1];
    top = p00 * (65536 - fx) + p01 * fx;
    bot = p10 * (65536 - fx) + p11 * fx;
    q = top * (65536 - fy) + bot * fy;
    r.pixel = q[39:32];
    r.hit = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    warp_res_t want;
    if (!rst_n) begin
      regs <= '{coef_xx: 63856, coef_xy: 15754, coef_yx: -52723, coef_yy: 35919,
                offset_x: 3376802, offset_y: 20292633, src_w: 512, src_h: 512};
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          awb_pkg::REG_COEF_XX:  regs.coef_xx  <= cfg_data;
          awb_pkg::REG_COEF_XY:  regs.coef_xy  <= cfg_data;
          awb_pkg::REG_COEF_YX:  regs.coef_yx  <= cfg_data;
          awb_pkg::REG_COEF_YY:  regs.coef_yy  <= cfg_data;
          awb_pkg::REG_OFFSET_X: regs.offset_x <= cfg_data;
          awb_pkg::REG_OFFSET_Y: regs.offset_y <= cfg_data;
          awb_pkg::REG_SRC_W:    regs.src_w    <= cfg_data[awb_pkg::DIM_W-1:0];
          awb_pkg::REG_SRC_H:    regs.src_h    <= cfg_data[awb_pkg::DIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_operation == awb_pkg::OP_WRITE)
          frame[in_coord_y * awb_pkg::MAX_SRC_DIM + in_coord_x] = in_pixel_in;
        else
          due_q.push_back(warp_sample(in_coord_x, in_coord_y));
      end
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          report("unexpected word", out_pixel_out, -1);
        end else begin
          want = due_q.pop_front();
          if (out_pixel_out !== want.pixel) report("pixel_out", out_pixel_out, want.pixel);
          if (out_inside_res !== want.hit)
            report("inside_res", out_inside_res, want.hit);
        end
      end
    end
  end

endmodule

// File: tb/affine_warp_bilinear_tb.sv
module affine_warp_bilinear_tb;

  localparam int IDLE_LIMIT = 5000;   // cycles with no word moving on either side
  localparam int HOLD_LEN   = 400;    // the one long receiver hold-off

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = awb_pkg::OP_WRITE;
  logic [8:0]  in_coord_x = '0;
  logic [8:0]  in_coord_y = '0;
  logic [7:0]  in_pixel_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_pixel_out;
  logic        out_inside_res;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;

  // shadow of the registers, only used to steer samples onto written pixels
  awb_pkg::cfg_t shadow = '{coef_xx: 63856, coef_xy: 15754, coef_yx: -52723,
                            coef_yy: 35919, offset_x: 3376802, offset_y: 20292633,
                            src_w: 512, src_h: 512};
  bit   loaded [0:awb_pkg::MAX_SRC_DIM*awb_pkg::MAX_SRC_DIM-1];
  int   words_sent = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;
  bit   held = 0;

  affine_warp_bilinear dut (.*);

  affine_warp_bilinear_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung pipe ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: stretches of differing stall patterns, plus one long hold-off
  // so the pipe fills up and pushes back on the sender
  initial begin
    int len;
    int mode;
    @(posedge clk iff rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(10, 60);
      repeat (len) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 4) != 0);
        endcase
        @(posedge clk);
      end
      if (!held && words_sent > 300) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        held = 1;
      end
    end
  end

  // one word on the input channel; valid drops only when a gap is chosen
  task automatic send_word(logic op, logic [8:0] x, logic [8:0] y, logic [7:0] p);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_operation <= op;
    in_coord_x <= x;
    in_coord_y <= y;
    in_pixel_in <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (op == awb_pkg::OP_WRITE) loaded[y * awb_pkg::MAX_SRC_DIM + x] = 1'b1;
  endtask

  // a sample preceded by writes to any neighbour pixel not yet loaded
  task automatic sample_at(logic [8:0] x, logic [8:0] y);
    longint sx, sy, nx, ny;
    sx = longint'(shadow.coef_xx) * longint'(x) + longint'(shadow.coef_xy) * longint'(y)
         + longint'(shadow.offset_x);
    sy = longint'(shadow.coef_yx) * longint'(x) + longint'(shadow.coef_yy) * longint'(y)
         + longint'(shadow.offset_y);
    nx = sx >>> 16;
    ny = sy >>> 16;
    if (nx >= 0 && ny >= 0 && nx < awb_pkg::MAX_SRC_DIM - 1 &&
        ny < awb_pkg::MAX_SRC_DIM - 1) begin
      for (int dy = 0; dy < 2; dy++)
        for (int dx = 0; dx < 2; dx++)
          if (!loaded[(ny + dy) * awb_pkg::MAX_SRC_DIM + nx + dx])
            send_word(awb_pkg::OP_WRITE, 9'(nx + dx), 9'(ny + dy), 8'($urandom));
    end
    send_word(awb_pkg::OP_SAMPLE, x, y, 8'($urandom));
  endtask

  // wait for the pipe to empty; writes leave no result so allow extra cycles
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      awb_pkg::REG_COEF_XX:  shadow.coef_xx = val;
      awb_pkg::REG_COEF_XY:  shadow.coef_xy = val;
      awb_pkg::REG_COEF_YX:  shadow.coef_yx = val;
      awb_pkg::REG_COEF_YY:  shadow.coef_yy = val;
      awb_pkg::REG_OFFSET_X: shadow.offset_x = val;
      awb_pkg::REG_OFFSET_Y: shadow.offset_y = val;
      awb_pkg::REG_SRC_W:    shadow.src_w = val[awb_pkg::DIM_W-1:0];
      default:               shadow.src_h = val[awb_pkg::DIM_W-1:0];
    endcase
    @(posedge clk);
  endtask

  task automatic load_regs(int xx, int xy, int yx, int yy, int ox, int oy, int w, int h);
    drain();
    set_reg(awb_pkg::REG_COEF_XX, xx);
    set_reg(awb_pkg::REG_COEF_XY, xy);
    set_reg(awb_pkg::REG_COEF_YX, yx);
    set_reg(awb_pkg::REG_COEF_YY, yy);
    set_reg(awb_pkg::REG_OFFSET_X, ox);
    set_reg(awb_pkg::REG_OFFSET_Y, oy);
    set_reg(awb_pkg::REG_SRC_W, w);
    set_reg(awb_pkg::REG_SRC_H, h);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1);        // too small: all outside
      1: return $urandom_range(513, 1023);   // beyond the store: clamped
      2, 3, 4: return $urandom_range(2, 512);
      default: return $urandom_range(2, 64);
    endcase
  endfunction

  initial begin
    int xx, xy, yx, yy, ox, oy;
    logic [8:0] x, y;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset matrix: store corners at both pixel extremes, sample the corners
    send_word(awb_pkg::OP_WRITE, 9'd0, 9'd0, 8'd0);
    send_word(awb_pkg::OP_WRITE, 9'd511, 9'd511, 8'd255);
    send_word(awb_pkg::OP_WRITE, 9'd511, 9'd0, 8'd255);
    send_word(awb_pkg::OP_WRITE, 9'd0, 9'd511, 8'd0);
    sample_at(9'd0, 9'd0);
    sample_at(9'd511, 9'd511);
    sample_at(9'd0, 9'd511);
    sample_at(9'd511, 9'd0);

    // near-identity with a fraction: right and bottom edge sit on the bound
    load_regs(65536, 0, 0, 65536, 32'h8000, 32'h4000, 512, 512);
    sample_at(9'd510, 9'd510);
    sample_at(9'd511, 9'd0);
    sample_at(9'd0, 9'd511);
    sample_at(9'd0, 9'd0);

    // smallest usable source
    load_regs(65536, 0, 0, 65536, 32'hFFFF, 32'h0001, 2, 2);
    sample_at(9'd0, 9'd0);
    sample_at(9'd1, 9'd0);
    sample_at(9'd0, 9'd1);

    // size below two and size beyond the store
    load_regs(65536, 0, 0, 65536, 0, 0, 1, 0);
    sample_at(9'd0, 9'd0);
    load_regs(65536, 0, 0, 65536, 0, 0, 1023, 1023);
    sample_at(9'd510, 9'd3);
    sample_at(9'd511, 9'd3);

    // coefficient and offset extremes
    load_regs(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
              32'h80000000, 32'h7FFFFFFF, 512, 512);
    sample_at(9'd511, 9'd511);
    sample_at(9'd0, 9'd0);
    load_regs(0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 512, 512);
    sample_at(9'd1, 9'd1);
    load_regs(0, 0, 0, 0, 32'h01FE_FFFF, 32'h01FE_0001, 512, 512);
    sample_at(9'd511, 9'd511);

    // random phases: mostly mild scale/shear maps with random content
    for (int ph = 0; ph < 8; ph++) begin
      if ($urandom_range(0, 5) == 0) begin
        xx = $urandom; xy = $urandom; yx = $urandom; yy = $urandom;
        ox = $urandom; oy = $urandom;
      end else begin
        xx = int'($urandom_range(0, 80000)) - 20000;
        xy = int'($urandom_range(0, 40000)) - 20000;
        yx = int'($urandom_range(0, 40000)) - 20000;
        yy = int'($urandom_range(0, 80000)) - 20000;
        ox = int'($urandom_range(0, 32'h00C8FFFF)) - 32'h00100000;
        oy = int'($urandom_range(0, 32'h00C8FFFF)) - 32'h00100000;
      end
      load_regs(xx, xy, yx, yy, ox, oy, pick_dim(), pick_dim());
      repeat (100) begin
        if ($urandom_range(0, 1) == 1) begin
          x = 9'($urandom_range(0, 63));
          y = 9'($urandom_range(0, 63));
        end else begin
          x = 9'($urandom);
          y = 9'($urandom);
        end
        if ($urandom_range(0, 9) < 4) send_word(awb_pkg::OP_WRITE, x, y, 8'($urandom));
        else sample_at(x, y);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
